// ----- rtl/dtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types, widths and the thermistor calibration table for the dual
// thermistor to Celsius converter.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int TableLen = 39;
    localparam int TopIndex = 38;
    localparam int RawW     = 8;
    localparam int CelW     = 9;
    localparam int IdxW     = 6;

    typedef logic [RawW-1:0]        t_raw;
    typedef logic signed [CelW-1:0] t_cel;
    typedef logic [IdxW-1:0]        t_idx;

    localparam t_raw ThermTable [TableLen] = '{
        8'd248, 8'd246, 8'd243, 8'd240, 8'd235, 8'd230, 8'd224, 8'd217,
        8'd208, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140, 8'd128,
        8'd116, 8'd104, 8'd93,  8'd83,  8'd74,  8'd65,  8'd58,  8'd51,
        8'd45,  8'd40,  8'd35,  8'd31,  8'd27,  8'd24,  8'd21,  8'd19,
        8'd17,  8'd15,  8'd13,  8'd12,  8'd11,  8'd9,   8'd8
    };

    localparam t_idx TopIdx       = t_idx'(TopIndex);
    localparam t_cel FaultCelsius = t_cel'(150);
    localparam t_cel BaseCelsius  = t_cel'(-40);

    typedef struct packed {
        t_cel celsius;
        logic fault;
    } t_lane_res;

endpackage
`default_nettype wire

// ----- rtl/dtc_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_lane
// One conversion lane: table search in the first stage, piecewise linear
// interpolation or extrapolation in the second stage.
// ----------------------------------------------------------------------------
module dtc_lane (
    input  wire logic              i_clk,
    input  wire dtc_pkg::t_raw     i_raw,
    output dtc_pkg::t_lane_res     o_res
);

    dtc_pkg::t_raw      r_raw;
    dtc_pkg::t_idx      r_idx;
    dtc_pkg::t_idx      n_idx;
    dtc_pkg::t_lane_res r_res;
    dtc_pkg::t_lane_res n_res;

    dtc_pkg::t_idx nxt_idx;
    dtc_pkg::t_raw lo;
    dtc_pkg::t_raw hi;
    logic [7:0]    span8;
    logic [3:0]    span;
    logic [7:0]    diff8;
    logic [3:0]    d;
    logic [6:0]    five_d;
    logic [6:0]    s1, s2, s3, s4;
    logic [2:0]    q;
    logic          over;
    logic [7:0]    ext8;
    logic [2:0]    e;
    logic [5:0]    five_e;
    logic [4:0]    drop;
    logic [7:0]    idx5;
    dtc_pkg::t_cel base;

    // search: last entry not below the reading
    always_comb begin
        n_idx = '0;
        for (int j = 0; j < dtc_pkg::TableLen; j++) begin
            if (dtc_pkg::ThermTable[j] >= i_raw) begin
                n_idx = dtc_pkg::t_idx'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw <= i_raw;
        r_idx <= n_idx;
    end

    always_comb begin
        nxt_idx = (r_idx == dtc_pkg::TopIdx) ? r_idx : r_idx + 1'b1;
        lo      = dtc_pkg::ThermTable[r_idx];
        hi      = dtc_pkg::ThermTable[nxt_idx];
        span8   = lo - hi;
        span    = span8[3:0];
        diff8   = lo - r_raw;
        d       = diff8[3:0];
        five_d  = {1'b0, d, 2'b00} + {3'b000, d};
        s1      = {3'b000, span};
        s2      = {2'b00, span, 1'b0};
        s3      = s2 + s1;
        s4      = {1'b0, span, 2'b00};
        q       = 3'(five_d >= s1) + 3'(five_d >= s2) + 3'(five_d >= s3)
                + 3'(five_d >= s4);
        over    = r_raw > dtc_pkg::ThermTable[0];
        ext8    = r_raw - dtc_pkg::ThermTable[0];
        e       = ext8[2:0];
        five_e  = {1'b0, e, 2'b00} + {3'b000, e};
        drop    = five_e[5:1];
        idx5    = {r_idx, 2'b00} + {2'b00, r_idx};
        base    = $signed({1'b0, idx5}) + dtc_pkg::BaseCelsius;

        n_res.fault = (r_idx == dtc_pkg::TopIdx);
        if (n_res.fault) begin
            n_res.celsius = dtc_pkg::FaultCelsius;
        end else if (over) begin
            n_res.celsius = dtc_pkg::BaseCelsius - $signed({4'b0000, drop});
        end else begin
            n_res.celsius = base + $signed({6'b000000, q});
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// ----- rtl/dtc_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_merge
// Combines both lane results into the fused temperature and registers the
// result transfer with its strobe.
// ----------------------------------------------------------------------------
module dtc_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire dtc_pkg::t_lane_res i_res_one,
    input  wire dtc_pkg::t_lane_res i_res_two,
    output logic                   o_strobe,
    output dtc_pkg::t_cel          o_celsius_one,
    output dtc_pkg::t_cel          o_celsius_two,
    output dtc_pkg::t_cel          o_celsius_combined
);

    logic                  r_strobe;
    dtc_pkg::t_cel         r_one, r_two, r_comb;
    dtc_pkg::t_cel         n_comb;
    logic signed [9:0]     sum;
    logic signed [9:0]     adj;
    logic signed [9:0]     mean;

    always_comb begin
        sum  = 10'(i_res_one.celsius) + 10'(i_res_two.celsius);
        adj  = sum + {9'd0, sum[9]};
        mean = adj >>> 1;
        if (i_res_one.fault && !i_res_two.fault) begin
            n_comb = i_res_two.celsius;
        end else if (i_res_two.fault) begin
            n_comb = i_res_one.celsius;
        end else begin
            n_comb = mean[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
        r_one  <= i_res_one.celsius;
        r_two  <= i_res_two.celsius;
        r_comb <= n_comb;
    end

    assign o_strobe           = r_strobe;
    assign o_celsius_one      = r_one;
    assign o_celsius_two      = r_two;
    assign o_celsius_combined = r_comb;

endmodule
`default_nettype wire

// ----- rtl/dual_thermistor_to_celsius_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_thermistor_to_celsius_top
// Converts a pair of raw thermistor bytes to Celsius in two parallel lanes
// and merges them into a combined temperature.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_raw_one / i_raw_two and raise start; the pair transfers at a
//   clock edge with start high and busy low. busy is always low, so a new
//   pair may transfer on every cycle.
//   Each pair yields one result: o_celsius_one, o_celsius_two and
//   o_celsius_combined, shown for one cycle with o_strobe high.
//   Each result passes through the table search register, the interpolation
//   register and the merge register before it transfers.
//   Throughput: one pair per cycle; busy stays low and every stage takes a
//   new pair on each cycle.
//   A reading of 8 or less reports 150 (sensor fault).
//   Reset (synchronous, active low) clears the strobe pipeline; pairs in
//   flight are dropped. The receiver cannot stall: every strobed result
//   must be taken in its cycle.
// ----------------------------------------------------------------------------
module dual_thermistor_to_celsius_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire dtc_pkg::t_raw i_raw_one,
    input  wire dtc_pkg::t_raw i_raw_two,
    output logic               o_strobe,
    output dtc_pkg::t_cel      o_celsius_one,
    output dtc_pkg::t_cel      o_celsius_two,
    output dtc_pkg::t_cel      o_celsius_combined
);

    logic [1:0]         r_vld;
    logic               accept;
    dtc_pkg::t_lane_res res_one;
    dtc_pkg::t_lane_res res_two;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[0], accept};
        end
    end

    dtc_lane u_lane_one (
        .i_clk (i_clk),
        .i_raw (i_raw_one),
        .o_res (res_one)
    );

    dtc_lane u_lane_two (
        .i_clk (i_clk),
        .i_raw (i_raw_two),
        .o_res (res_two)
    );

    dtc_merge u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vld              (r_vld[1]),
        .i_res_one          (res_one),
        .i_res_two          (res_two),
        .o_strobe           (o_strobe),
        .o_celsius_one      (o_celsius_one),
        .o_celsius_two      (o_celsius_two),
        .o_celsius_combined (o_celsius_combined)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_strobe)
        else $error("result strobe missing three cycles after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 3))
        else $error("result strobe without a matching transfer");

    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_celsius_one == dtc_pkg::FaultCelsius
            && o_celsius_two != dtc_pkg::FaultCelsius)
        |-> o_celsius_combined == o_celsius_two)
        else $error("combined value does not fall back to channel two");

    a_mean_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_celsius_one != dtc_pkg::FaultCelsius
            && o_celsius_two != dtc_pkg::FaultCelsius)
        |-> ((o_celsius_combined >= o_celsius_one
                && o_celsius_combined <= o_celsius_two)
            || (o_celsius_combined >= o_celsius_two
                && o_celsius_combined <= o_celsius_one)))
        else $error("combined mean outside the channel values");

endmodule
`default_nettype wire

// ----- tb/sv/dual_thermistor_to_celsius_top_test.sv -----
// ----------------------------------------------------------------------------
// dual_thermistor_to_celsius_top_test
// Self-checking bench for the dual thermistor converter. Reading pairs are
// pushed through the start/busy command port. Each transfer is predicted with
// a table search and a linear step interpolation. Every strobed result is
// compared field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module dual_thermistor_to_celsius_top_test;

    localparam int StepDeg    = 5;
    localparam int FracScale  = 100;
    localparam int MaxReports = 10;
    localparam int PhaseItems = 460;
    localparam int DrainWait  = 10;
    localparam int CycleLimit = 200000;

    typedef struct {
        dtc_pkg::t_cel one;
        dtc_pkg::t_cel two;
        dtc_pkg::t_cel combined;
    } t_celsius_set;

    class celsius_scoreboard;
        t_celsius_set pending_celsius[$];
        int mismatches;
        int pairs_seen;
        int results_seen;
        int fault_readings;
        int high_readings;

        function dtc_pkg::t_cel to_celsius(dtc_pkg::t_raw raw);
            int r;
            int idx;
            int lo;
            int hi;
            int frac;
            r   = int'(raw);
            idx = dtc_pkg::TopIndex;
            while (idx > 0 && int'(dtc_pkg::ThermTable[idx]) < r) idx--;
            if (idx == dtc_pkg::TopIndex) begin
                return dtc_pkg::FaultCelsius;
            end
            lo   = int'(dtc_pkg::ThermTable[idx]);
            hi   = int'(dtc_pkg::ThermTable[idx + 1]);
            frac = ((r - lo) * FracScale) / (hi - lo);
            return dtc_pkg::t_cel'(idx * StepDeg + int'(dtc_pkg::BaseCelsius)
                                   + (StepDeg * frac) / FracScale);
        endfunction

        function void note_pair(dtc_pkg::t_raw raw_one, dtc_pkg::t_raw raw_two);
            t_celsius_set exp_set;
            exp_set.one = to_celsius(raw_one);
            exp_set.two = to_celsius(raw_two);
            if (exp_set.one == dtc_pkg::FaultCelsius
                    && exp_set.two != dtc_pkg::FaultCelsius) begin
                exp_set.combined = exp_set.two;
            end else if (exp_set.two == dtc_pkg::FaultCelsius) begin
                exp_set.combined = exp_set.one;
            end else begin
                exp_set.combined = dtc_pkg::t_cel'((int'(exp_set.one)
                                                    + int'(exp_set.two)) / 2);
            end
            pairs_seen++;
            fault_readings += (exp_set.one == dtc_pkg::FaultCelsius)
                            + (exp_set.two == dtc_pkg::FaultCelsius);
            high_readings  += (int'(raw_one) > int'(dtc_pkg::ThermTable[0]))
                            + (int'(raw_two) > int'(dtc_pkg::ThermTable[0]));
            pending_celsius.insert(pending_celsius.size(), exp_set);
        endfunction

        function void check_result(dtc_pkg::t_cel got_one, dtc_pkg::t_cel got_two,
                                   dtc_pkg::t_cel got_comb);
            t_celsius_set exp_set;
            results_seen++;
            if (pending_celsius.size() == 0) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("unexpected result %0d/%0d/%0d with nothing pending",
                             got_one, got_two, got_comb);
                end
                return;
            end
            exp_set = pending_celsius.pop_front();
            if (got_one !== exp_set.one || got_two !== exp_set.two
                    || got_comb !== exp_set.combined) begin
                mismatches++;
                if (mismatches <= MaxReports) begin
                    $display("mismatch on result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                             results_seen, exp_set.one, exp_set.two, exp_set.combined,
                             got_one, got_two, got_comb);
                end
            end
        endfunction

        function int pending();
            return pending_celsius.size();
        endfunction

        function int failures();
            return mismatches + pending_celsius.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    dtc_pkg::t_raw i_raw_one;
    dtc_pkg::t_raw i_raw_two;
    logic          o_strobe;
    dtc_pkg::t_cel o_celsius_one;
    dtc_pkg::t_cel o_celsius_two;
    dtc_pkg::t_cel o_celsius_combined;

    celsius_scoreboard sb;
    int cycle_count;

    dual_thermistor_to_celsius_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_raw_one          (i_raw_one),
        .i_raw_two          (i_raw_two),
        .o_strobe           (o_strobe),
        .o_celsius_one      (o_celsius_one),
        .o_celsius_two      (o_celsius_two),
        .o_celsius_combined (o_celsius_combined)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        sb          = new;
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                sb.note_pair(i_raw_one, i_raw_two);
            end
            if (o_strobe === 1'b1) begin
                sb.check_result(o_celsius_one, o_celsius_two, o_celsius_combined);
            end
        end
    end

    task automatic send_pair(input dtc_pkg::t_raw raw_one, input dtc_pkg::t_raw raw_two,
                             input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            i_raw_one <= dtc_pkg::t_raw'($urandom);
            i_raw_two <= dtc_pkg::t_raw'($urandom);
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_raw_one <= raw_one;
        i_raw_two <= raw_two;
        do @(posedge i_clk); while (busy !== 1'b0);
        @(negedge i_clk);
    endtask

    function automatic dtc_pkg::t_raw pick_raw();
        int idx;
        int val;
        case ($urandom_range(9))
            4: val = $urandom_range(int'(dtc_pkg::ThermTable[dtc_pkg::TopIndex]));
            5: val = $urandom_range(255, int'(dtc_pkg::ThermTable[0]) + 1);
            6, 7, 8: begin
                idx = $urandom_range(dtc_pkg::TopIndex);
                val = int'(dtc_pkg::ThermTable[idx]) + $urandom_range(2) - 1;
            end
            9: begin
                idx = $urandom_range(dtc_pkg::TopIndex);
                val = int'(dtc_pkg::ThermTable[idx]);
            end
            default: val = $urandom_range(255);
        endcase
        return dtc_pkg::t_raw'(val);
    endfunction

    initial begin
        dtc_pkg::t_raw directed_one[$];
        dtc_pkg::t_raw directed_two[$];
        int            idle_pct[3];
        start     = 1'b0;
        i_rst_n   = 1'b0;
        i_raw_one = '0;
        i_raw_two = '0;
        idle_pct  = '{8, 74, 0};
        directed_one = '{8'd0,   8'd255, 8'd8,   8'd9,   8'd248, 8'd249, 8'd0,
                         8'd255, 8'd128, 8'd1,   8'd254, 8'd255, 8'd9,   8'd170,
                         8'd127, 8'h55,  8'hAA,  8'd8,   8'd200, 8'd246, 8'd11,
                         8'd12,  8'hFF,  8'd100};
        directed_two = '{8'd255, 8'd0,   8'd9,   8'd8,   8'd248, 8'd246, 8'd0,
                         8'd255, 8'd140, 8'd2,   8'd3,   8'd248, 8'd10,  8'd60,
                         8'd128, 8'hAA,  8'h55,  8'd8,   8'd100, 8'd249, 8'd10,
                         8'd13,  8'h00,  8'd7};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_one[k]) begin
            send_pair(directed_one[k], directed_two[k], 0);
        end
        foreach (idle_pct[p]) begin
            repeat (PhaseItems) send_pair(pick_raw(), pick_raw(), idle_pct[p]);
        end
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        $display("sent %0d reading pairs and checked %0d results", sb.pairs_seen,
                 sb.results_seen);
        $display("coverage: %0d fault readings, %0d readings above the table top",
                 sb.fault_readings, sb.high_readings);
        if (sb.failures() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("status: fail");
        end
        $finish;
    end

endmodule
